// ----- hw/rtl/grfp_pkg.sv -----
// Shared constants and types for the gyro rate frame parser.
package grfp_pkg;

  localparam logic [7:0] HEADER_RESET      = 8'hDD;
  localparam int         FRAME_LEN         = 7;
  localparam int         SUM_LEN           = 3;
  localparam logic [2:0] LAST_POS          = 3'(FRAME_LEN - 1);
  localparam int         BLOCK_LEN_DEFAULT = 64;
  localparam int         SLOT_IDX_W        = 6;
  localparam int         RATE_W            = 24;
  localparam int         LOSS_W            = 16;

  typedef struct packed {
    logic                     ok;
    logic signed [RATE_W-1:0] rate;
  } chk_result_t;

endpackage

// ----- hw/rtl/grfp_check.sv -----
// Frame checksum compare and rate assembly.
module grfp_check import grfp_pkg::*; (
  input  logic [7:0]  b0,
  input  logic [7:0]  b1,
  input  logic [7:0]  b2,
  input  logic [7:0]  b5,
  input  logic [7:0]  b6,
  output chk_result_t result
);

  logic [9:0]  sum;
  logic [15:0] chk;

  // three bytes never exceed 10 bits, so the 16-bit wrap never happens
  assign sum         = 10'(b0) + 10'(b1) + 10'(b2);
  assign chk         = {b5, b6};
  assign result.ok   = (16'(sum) == chk);
  assign result.rate = {b1, b2, b0};

endmodule

// ----- hw/rtl/gyro_rate_frame_parser_unit.sv -----
// Top level: byte-stream header hunt, frame collect, checksum and sample slotting.
// Output: a result is registered in the result register once the seventh frame byte has passed the input register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the sides, so a waiting result stalls input only when a new result is due.
// Reset (rst, synchronous): hunting for header, slot and loss counters zero,
// header byte 0xDD, both pipeline registers empty.
module gyro_rate_frame_parser_unit import grfp_pkg::*; #(
  parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     frame_ok,
  output logic signed [RATE_W-1:0] rate_value,
  output logic [SLOT_IDX_W-1:0]    slot_index,
  output logic                     block_done,
  output logic [LOSS_W-1:0]        loss_total
);

  localparam int SlotW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(BLOCK_LEN - 1);

  logic [7:0]        header_byte;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              in_frame;
  logic [2:0]        byte_pos;
  logic [7:0]        frame_bytes [FRAME_LEN-1];
  logic [SlotW-1:0]  sample_slot;
  logic [LOSS_W-1:0] loss_count;
  logic [LOSS_W-1:0] loss_count_next;
  logic              s1_emit;
  logic              s1_go;
  chk_result_t       chk;
  logic [SlotW+SLOT_IDX_W-1:0] slot_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
    end else if (cfg_valid) begin
      header_byte <= cfg_data;
    end
  end

  // the seventh frame byte is the only one that yields a transaction
  assign s1_emit  = in_frame && (byte_pos == LAST_POS);
  assign s1_go    = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  grfp_check u_check (
    .b0     (frame_bytes[0]),
    .b1     (frame_bytes[1]),
    .b2     (frame_bytes[2]),
    .b5     (frame_bytes[5]),
    .b6     (s1_byte),
    .result (chk)
  );

  always_comb begin
    loss_count_next = loss_count;
    if (!chk.ok && (loss_count != {LOSS_W{1'b1}})) begin
      loss_count_next = loss_count + LOSS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_pos    <= 3'd0;
      sample_slot <= '0;
      loss_count  <= '0;
    end else if (s1_go) begin
      if (!in_frame) begin
        if (s1_byte == header_byte) begin
          in_frame <= 1'b1;
          byte_pos <= 3'd0;
        end
      end else if (s1_emit) begin
        in_frame <= 1'b0;
        byte_pos <= 3'd0;
        if (chk.ok) begin
          sample_slot <= (sample_slot == SlotLast) ? '0 : sample_slot + SlotW'(1);
        end
        loss_count <= loss_count_next;
      end else begin
        byte_pos <= byte_pos + 3'd1;
      end
    end
  end

  // byte 6 is used straight from the input register
  always_ff @(posedge clk) begin
    if (s1_go && in_frame && !s1_emit) begin
      frame_bytes[byte_pos] <= s1_byte;
    end
  end

  assign slot_ext = {{SLOT_IDX_W{1'b0}}, sample_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      frame_ok   <= chk.ok;
      rate_value <= chk.ok ? chk.rate : '0;
      slot_index <= chk.ok ? slot_ext[SLOT_IDX_W-1:0] : '0;
      block_done <= chk.ok && (sample_slot == SlotLast);
      loss_total <= loss_count_next;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for gyro_rate_frame_parser_unit: byte stream in, parsed frames out.
module testbench import grfp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_PCT   = 18;
  localparam int WDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic                     ok;
    logic signed [RATE_W-1:0] rate;
    logic [SLOT_IDX_W-1:0]    slot;
    logic                     done;
    logic [LOSS_W-1:0]        loss;
  } frame_res_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [7:0]               cfg_data = 8'h00;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               rx_byte = 8'h00;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     frame_ok;
  logic signed [RATE_W-1:0] rate_value;
  logic [SLOT_IDX_W-1:0]    slot_index;
  logic                     block_done;
  logic [LOSS_W-1:0]        loss_total;

  gyro_rate_frame_parser_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_ok   (frame_ok),
    .rate_value (rate_value),
    .slot_index (slot_index),
    .block_done (block_done),
    .loss_total (loss_total)
  );

  always #5 clk = ~clk;

  // stimulus bytes waiting to be driven, and parsed frames waiting to come out
  logic [7:0] byte_q[$];
  frame_res_t parsed_q[$];

  // parser state mirror
  logic [7:0] hdr = HEADER_RESET;
  logic       collecting = 1'b0;
  int         pos = 0;
  logic [7:0] fbytes[FRAME_LEN];
  int         slot_cnt = 0;
  int         loss_cnt = 0;

  int   mismatches = 0;
  int   bytes_taken = 0;
  int   good_frames = 0;
  int   bad_frames = 0;
  int   block_wraps = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  logic no_gaps = 1'b0;

  task automatic parse_byte(input logic [7:0] b);
    frame_res_t r;
    logic [15:0] sum;
    bytes_taken++;
    if (!collecting) begin
      if (b == hdr) begin
        collecting = 1'b1;
        pos = 0;
      end
    end else begin
      // a header value seen here is plain frame data
      fbytes[pos] = b;
      pos++;
      if (pos == FRAME_LEN) begin
        collecting = 1'b0;
        pos = 0;
        sum = 16'(fbytes[0]) + 16'(fbytes[1]) + 16'(fbytes[2]);
        r.ok = 1'b0;
        r.rate = '0;
        r.slot = '0;
        r.done = 1'b0;
        if (sum == {fbytes[5], fbytes[6]}) begin
          r.ok = 1'b1;
          r.rate = {fbytes[1], fbytes[2], fbytes[0]};
          r.slot = slot_cnt[SLOT_IDX_W-1:0];
          slot_cnt++;
          if (slot_cnt >= BLOCK_LEN_DEFAULT) begin
            slot_cnt = 0;
            r.done = 1'b1;
            block_wraps++;
          end
          good_frames++;
        end else begin
          if (loss_cnt < 65535) loss_cnt++;
          bad_frames++;
        end
        r.loss = loss_cnt[LOSS_W-1:0];
        parsed_q.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // predictor and result checker
  always @(posedge clk) begin
    frame_res_t r;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) parse_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected frame result, expected none, actual ok=%0b loss=%0d",
                     $realtime, frame_ok, loss_total);
          mismatches++;
        end else begin
          r = parsed_q.pop_front();
          check_field("frame_ok", r.ok, frame_ok);
          check_field("rate_value", longint'(r.rate), longint'(rate_value));
          check_field("slot_index", r.slot, slot_index);
          check_field("block_done", r.done, block_done);
          check_field("loss_total", r.loss, loss_total);
        end
      end
    end
  end

  // driver: new byte after each transaction, random gaps, random output stalls
  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_q.size() > 0 && (no_gaps || $urandom_range(99) >= STALL_PCT)) begin
        in_valid <= 1'b1;
        rx_byte <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("gyro_rate_frame_parser_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return hdr;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == hdr);
    return b;
  endfunction

  task automatic throttle();
    while (byte_q.size() > 32) @(posedge clk);
  endtask

  task automatic feed_frame(input bit good);
    logic [7:0] b[FRAME_LEN];
    logic [15:0] sum;
    throttle();
    foreach (b[i]) b[i] = pick_byte();
    sum = 16'(b[0]) + 16'(b[1]) + 16'(b[2]);
    if (good)
      {b[5], b[6]} = sum;
    else if ($urandom_range(1))
      {b[5], b[6]} = sum ^ (16'h1 << $urandom_range(15));
    else if ({b[5], b[6]} == sum)
      b[6] = b[6] ^ 8'h01;
    byte_q.push_back(hdr);
    foreach (b[i]) byte_q.push_back(b[i]);
  endtask

  task automatic drain();
    while (byte_q.size() > 0 || in_valid || parsed_q.size() > 0) @(posedge clk);
    // bytes with no result may still sit in the input register
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    hdr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int nbytes, input int steady_bytes, input bit pause_mid);
    int start;
    int roll;
    int n;
    bit paused;
    start = bytes_taken + byte_q.size();
    paused = 1'b0;
    while (bytes_taken + byte_q.size() - start < nbytes) begin
      n = bytes_taken + byte_q.size() - start;
      no_gaps = (n < steady_bytes);
      if (pause_mid && !paused && n >= nbytes / 2) begin
        drain();
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 70) begin
        feed_frame(1'b1);
      end else if (roll < 82) begin
        feed_frame(1'b0);
      end else if (roll < 90) begin
        // truncated frame: the next header lands inside it as data
        throttle();
        byte_q.push_back(hdr);
        repeat ($urandom_range(6, 1)) byte_q.push_back(pick_byte());
      end else begin
        throttle();
        repeat ($urandom_range(3, 1)) byte_q.push_back(noise_byte());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle noise, max rate with header value inside the frame, min rate, bad checksum
    byte_q = '{8'h00,
               HEADER_RESET, 8'hFF, 8'h7F, 8'hFF, HEADER_RESET, 8'h00, 8'h02, 8'h7D,
               HEADER_RESET, 8'h00, 8'h80, 8'h00, 8'h12, 8'h34, 8'h00, 8'h80,
               HEADER_RESET, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 8'h07};
    drain();

    write_header(8'h00);
    run_random(560, 0, 1'b0);
    drain();

    write_header(8'hFF);
    run_random(560, 250, 1'b0);
    drain();

    write_header(HEADER_RESET);
    run_random(560, 0, 1'b1);
    drain();

    write_header(8'hA5);
    run_random(100, 0, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    $display("Run covered %0d bytes under headers 0xDD, 0x00, 0xFF and 0xA5:", bytes_taken);
    $display("  %0d good frames, %0d bad frames, %0d block wraps, final loss count %0d",
             good_frames, bad_frames, block_wraps, loss_cnt);
    if (mismatches == 0) begin
      $display("gyro_rate_frame_parser_unit verification clean");
    end else begin
      $display("gyro_rate_frame_parser_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- gyro_rate_frame_parser_unit.f -----
hw/rtl/grfp_pkg.sv
hw/rtl/grfp_check.sv
hw/rtl/gyro_rate_frame_parser_unit.sv
dv/testbench.sv
